### hw/rtl/rcpd_pkg.sv
// Shared types, register map and reset values for the RC pulse decoder.
package rcpd_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int TIME_BITS_DEF    = 16;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [15:0] SYNC_MIN_WIDTH_RST   = 16'd7000;
  localparam logic [3:0]  FRAME_CHANNELS_RST   = 4'd8;
  localparam logic [3:0]  FAILSAFE_CHANNEL_RST = 4'd1;
  localparam logic [15:0] FAILSAFE_LOW_RST     = 16'd1500;
  localparam logic [15:0] FAILSAFE_HIGH_RST    = 16'd4500;

  typedef enum logic [2:0] {
    REG_PPM_MODE         = 3'd0,
    REG_PPM_PULSE_LEVEL  = 3'd1,
    REG_SYNC_MIN_WIDTH   = 3'd2,
    REG_FRAME_CHANNELS   = 3'd3,
    REG_FAILSAFE_CHANNEL = 3'd4,
    REG_FAILSAFE_LOW     = 3'd5,
    REG_FAILSAFE_HIGH    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        ppm_mode;
    logic        ppm_pulse_level;
    logic [15:0] sync_min_width;
    logic [3:0]  frame_channels;
    logic [3:0]  failsafe_channel;
    logic [15:0] failsafe_low;
    logic [15:0] failsafe_high;
  } cfg_t;

  typedef struct packed {
    logic [15:0] capture_time;
    logic        pin_level;
    logic [3:0]  source_channel;
  } in_item_t;

  typedef struct packed {
    logic        width_valid;
    logic [3:0]  width_channel;
    logic [15:0] pulse_width;
    logic        sync_seen;
    logic [15:0] good_count;
    logic [15:0] noise_count;
  } out_item_t;

endpackage

### hw/rtl/rcpd_apb_regs.sv
// APB register file holding the decoder configuration.
module rcpd_apb_regs import rcpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppm_mode         <= 1'b0;
      cfg_r.ppm_pulse_level  <= 1'b1;
      cfg_r.sync_min_width   <= SYNC_MIN_WIDTH_RST;
      cfg_r.frame_channels   <= FRAME_CHANNELS_RST;
      cfg_r.failsafe_channel <= FAILSAFE_CHANNEL_RST;
      cfg_r.failsafe_low     <= FAILSAFE_LOW_RST;
      cfg_r.failsafe_high    <= FAILSAFE_HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PPM_MODE:         cfg_r.ppm_mode         <= pwdata[0];
        REG_PPM_PULSE_LEVEL:  cfg_r.ppm_pulse_level  <= pwdata[0];
        REG_SYNC_MIN_WIDTH:   cfg_r.sync_min_width   <= pwdata[15:0];
        REG_FRAME_CHANNELS:   cfg_r.frame_channels   <= pwdata[3:0];
        REG_FAILSAFE_CHANNEL: cfg_r.failsafe_channel <= pwdata[3:0];
        REG_FAILSAFE_LOW:     cfg_r.failsafe_low     <= pwdata[15:0];
        REG_FAILSAFE_HIGH:    cfg_r.failsafe_high    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_PPM_MODE:         prdata[0]    = cfg_r.ppm_mode;
      REG_PPM_PULSE_LEVEL:  prdata[0]    = cfg_r.ppm_pulse_level;
      REG_SYNC_MIN_WIDTH:   prdata[15:0] = cfg_r.sync_min_width;
      REG_FRAME_CHANNELS:   prdata[3:0]  = cfg_r.frame_channels;
      REG_FAILSAFE_CHANNEL: prdata[3:0]  = cfg_r.failsafe_channel;
      REG_FAILSAFE_LOW:     prdata[15:0] = cfg_r.failsafe_low;
      REG_FAILSAFE_HIGH:    prdata[15:0] = cfg_r.failsafe_high;
      default:              prdata       = '0;
    endcase
  end

endmodule

### hw/rtl/rc_pwm_ppm_pulse_decoder.sv
// Top level of the RC receiver pulse decoder: PWM capture and PPM frame decoding.
//
// Each input beat is one captured timer edge and yields exactly one result beat. A beat is held
// in an input register, decoded by a single pass of subtract and compare logic against the
// channel rise-time registers, the PPM slot state and the failsafe counters, and lands in an
// output register; that state is updated when the beat moves into the output register. A new
// beat is accepted every cycle while the output side keeps up. An accepted beat passes through
// the input register and then the output register before output valid rises; a stalled
// output holds the beat in the output register and, once the input register is also full,
// stalls the input. The user must write configuration through the APB port only while no
// beat is in flight; the block itself does not enforce this.
module rc_pwm_ppm_pulse_decoder import rcpd_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W    = (TIME_BITS > 16) ? TIME_BITS : 16;

  cfg_t cfg;

  rcpd_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage and output stage.
  logic      in_v_r;
  in_item_t  in_r;
  logic      out_v_r;
  out_item_t out_r;
  logic      advance;

  // Decoder state.
  logic [TIME_BITS-1:0] rise_r [NUM_CHANNELS];
  logic [TIME_BITS-1:0] last_edge_r;
  logic [3:0]           slot_r;
  logic [15:0]          good_r;
  logic [15:0]          noise_r;

  logic [TIME_BITS-1:0] last_edge_nxt;
  logic [3:0]           slot_nxt;
  logic [15:0]          good_nxt;
  logic [15:0]          noise_nxt;
  logic                 rise_we;
  logic [CH_IDX_W-1:0]  rise_idx;
  out_item_t            res;

  assign advance   = in_v_r & (~out_v_r | out_ready);
  assign in_ready  = ~in_v_r | advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    logic [TIME_BITS+15:0] t_ext;
    logic [TIME_BITS-1:0]  t;
    logic [3:0]            src_m1;
    logic                  src_ok;
    logic [TIME_BITS-1:0]  width;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS+15:0] width_ext;
    logic [CMP_W-1:0]      width_c;
    logic [CMP_W-1:0]      gap_c;
    logic                  valid;
    logic [3:0]            chan;
    logic                  sync;

    t_ext  = {{TIME_BITS{1'b0}}, in_r.capture_time};
    t      = t_ext[TIME_BITS-1:0];
    src_m1 = in_r.source_channel - 4'd1;
    src_ok = (in_r.source_channel != 4'd0) &&
             (in_r.source_channel <= 4'(NUM_CHANNELS));
    rise_idx = src_m1[CH_IDX_W-1:0];
    gap      = t - last_edge_r;
    gap_c    = CMP_W'(gap);

    valid         = 1'b0;
    chan          = 4'd0;
    width         = '0;
    sync          = 1'b0;
    rise_we       = 1'b0;
    last_edge_nxt = last_edge_r;
    slot_nxt      = slot_r;

    if (!cfg.ppm_mode) begin
      if (src_ok) begin
        if (in_r.pin_level) begin
          rise_we = 1'b1;
        end else begin
          width = t - rise_r[rise_idx];
          valid = 1'b1;
          chan  = in_r.source_channel;
        end
      end
    end else if (in_r.pin_level == cfg.ppm_pulse_level) begin
      last_edge_nxt = t;
      if (gap_c > CMP_W'(cfg.sync_min_width)) begin
        slot_nxt = 4'd1;
        sync     = 1'b1;
      end else if ((slot_r != 4'd0) && (slot_r <= cfg.frame_channels)) begin
        // Slots past the implemented channels still advance but report nothing.
        if (slot_r <= 4'(NUM_CHANNELS)) begin
          valid = 1'b1;
          chan  = slot_r;
          width = gap;
        end
        slot_nxt = slot_r + 4'd1;
      end
    end

    width_c   = CMP_W'(width);
    good_nxt  = good_r;
    noise_nxt = noise_r;
    if (valid && (chan == cfg.failsafe_channel)) begin
      if ((width_c > CMP_W'(cfg.failsafe_low)) && (width_c < CMP_W'(cfg.failsafe_high))) begin
        good_nxt = good_r + 16'd1;
      end else begin
        noise_nxt = noise_r + 16'd1;
      end
    end

    width_ext         = {16'd0, width};
    res.width_valid   = valid;
    res.width_channel = chan;
    res.pulse_width   = width_ext[15:0];
    res.sync_seen     = sync;
    res.good_count    = good_nxt;
    res.noise_count   = noise_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_r[i] <= '0;
      end
      last_edge_r <= '0;
      slot_r      <= 4'd0;
      good_r      <= 16'd0;
      noise_r     <= 16'd0;
    end else if (advance) begin
      if (rise_we) begin
        rise_r[rise_idx] <= last_edge_nxt_time();
      end
      last_edge_r <= last_edge_nxt;
      slot_r      <= slot_nxt;
      good_r      <= good_nxt;
      noise_r     <= noise_nxt;
    end
  end

  // Capture time of the beat in the input register, at the timer width.
  function automatic logic [TIME_BITS-1:0] last_edge_nxt_time();
    logic [TIME_BITS+15:0] ext;
    ext = {{TIME_BITS{1'b0}}, in_r.capture_time};
    return ext[TIME_BITS-1:0];
  endfunction

endmodule

### sim/tb.sv
// Self-checking testbench for the RC PWM/PPM pulse decoder: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import rcpd_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 105;
  localparam int HOLD_AT_BEAT = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT_BEAT = 800;

  typedef enum logic {ROW_CAPTURE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    reg_idx_t   reg_sel;
    logic [31:0] reg_value;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Decoder model state and its copy of the registers.
  cfg_t        model_cfg;
  logic [15:0] rise_time [NCH];
  logic [15:0] last_pulse_time;
  logic [3:0]  frame_slot;
  logic [15:0] good_tally;
  logic [15:0] noise_tally;

  // Stimulus generator state, kept apart from the model so that noise can break sequences.
  bit          gen_high [NCH];
  logic [15:0] gen_rise [NCH];
  logic [15:0] gen_last_pulse;

  out_item_t  expected_decodes [$];
  out_item_t  want_item;
  table_row_t stim_table [$];
  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int sender_mode = 0;

  rc_pwm_ppm_pulse_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    mismatch_count++;
  endtask

  function automatic void tally_failsafe(logic [3:0] chan, logic [15:0] width);
    if (chan != model_cfg.failsafe_channel) return;
    if (width > model_cfg.failsafe_low && width < model_cfg.failsafe_high)
      good_tally = good_tally + 16'd1;
    else
      noise_tally = noise_tally + 16'd1;
  endfunction

  function automatic out_item_t decode_capture(in_item_t c);
    out_item_t   r;
    logic [15:0] gap;
    r = '0;
    if (!model_cfg.ppm_mode) begin
      if (c.source_channel >= 1 && c.source_channel <= NCH) begin
        if (c.pin_level) begin
          rise_time[c.source_channel - 1] = c.capture_time;
        end else begin
          r.pulse_width   = c.capture_time - rise_time[c.source_channel - 1];
          r.width_valid   = 1'b1;
          r.width_channel = c.source_channel;
          tally_failsafe(r.width_channel, r.pulse_width);
        end
      end
    end else if (c.pin_level == model_cfg.ppm_pulse_level) begin
      gap = c.capture_time - last_pulse_time;
      last_pulse_time = c.capture_time;
      if (gap > model_cfg.sync_min_width) begin
        frame_slot  = 4'd1;
        r.sync_seen = 1'b1;
      end else if (frame_slot != 0 && frame_slot <= model_cfg.frame_channels) begin
        if (frame_slot <= NCH) begin
          r.width_valid   = 1'b1;
          r.width_channel = frame_slot;
          r.pulse_width   = gap;
          tally_failsafe(frame_slot, gap);
        end
        // A four-bit slot wraps from 15 to 0 and then waits for the next sync.
        frame_slot = frame_slot + 4'd1;
      end
    end
    r.good_count  = good_tally;
    r.noise_count = noise_tally;
    return r;
  endfunction

  function automatic logic [15:0] pick_width();
    int lo;
    int hi;
    int r;
    lo = model_cfg.failsafe_low;
    hi = model_cfg.failsafe_high;
    if (lo > hi) begin
      r = lo;
      lo = hi;
      hi = r;
    end
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(lo > 2 ? lo - 2 : 0, hi < 65533 ? hi + 2 : 65535));
    if (r < 7) return 16'($urandom_range(900, 2100));
    return 16'($urandom);
  endfunction

  function automatic in_item_t make_capture();
    in_item_t    c;
    int          r;
    int          ch;
    logic [15:0] gap;
    c.capture_time   = 16'($urandom);
    c.pin_level      = 1'($urandom);
    c.source_channel = 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) return c;
    if (!model_cfg.ppm_mode) begin
      // Well-formed rise/fall pairs per channel, interleaved across channels.
      ch = $urandom_range(1, NCH);
      if (!gen_high[ch - 1]) begin
        gen_rise[ch - 1] = 16'($urandom);
        c.capture_time = gen_rise[ch - 1];
        c.pin_level = 1'b1;
      end else begin
        c.capture_time = gen_rise[ch - 1] + pick_width();
        c.pin_level = 1'b0;
      end
      gen_high[ch - 1] = !gen_high[ch - 1];
      c.source_channel = 4'(ch);
    end else if (r < 30) begin
      // Trailing edge of a pulse, at the level that PPM decoding ignores.
      c.pin_level = !model_cfg.ppm_pulse_level;
      c.capture_time = gen_last_pulse + 16'($urandom_range(1, 400));
    end else begin
      if (r < 35) begin
        if (model_cfg.sync_min_width < 16'hFFFF)
          gap = 16'($urandom_range(int'(model_cfg.sync_min_width) + 1, 65535));
        else
          gap = 16'($urandom);
      end else begin
        gap = pick_width();
        if (gap > model_cfg.sync_min_width)
          gap = 16'($urandom_range(0, int'(model_cfg.sync_min_width)));
      end
      gen_last_pulse = gen_last_pulse + gap;
      c.pin_level = model_cfg.ppm_pulse_level;
      c.capture_time = gen_last_pulse;
    end
    return c;
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_capture(in_item_t c, bit typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = pick_gap(sender_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    predicted = decode_capture(c);
    expected_decodes.push_back(typed ? want : predicted);
    items_sent++;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk);
    // Let the pipeline settle before any register write.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PPM_MODE:         model_cfg.ppm_mode = value[0];
      REG_PPM_PULSE_LEVEL:  model_cfg.ppm_pulse_level = value[0];
      REG_SYNC_MIN_WIDTH:   model_cfg.sync_min_width = value[15:0];
      REG_FRAME_CHANNELS:   model_cfg.frame_channels = value[3:0];
      REG_FAILSAFE_CHANNEL: model_cfg.failsafe_channel = value[3:0];
      REG_FAILSAFE_LOW:     model_cfg.failsafe_low = value[15:0];
      REG_FAILSAFE_HIGH:    model_cfg.failsafe_high = value[15:0];
      default: ;
    endcase
  endtask

  function automatic table_row_t capture_row(int t, bit lvl, int ch);
    table_row_t row;
    row = '{kind: ROW_CAPTURE, reg_sel: REG_PPM_MODE, reg_value: '0,
            item: '0, typed: 1'b0, want: '0};
    row.item.capture_time   = 16'(t);
    row.item.pin_level      = lvl;
    row.item.source_channel = 4'(ch);
    return row;
  endfunction

  function automatic table_row_t known_row(int t, bit lvl, int ch, bit v, int wch, int w,
                                           bit s, int g, int n);
    table_row_t row;
    row = capture_row(t, lvl, ch);
    row.typed = 1'b1;
    row.want.width_valid   = v;
    row.want.width_channel = 4'(wch);
    row.want.pulse_width   = 16'(w);
    row.want.sync_seen     = s;
    row.want.good_count    = 16'(g);
    row.want.noise_count   = 16'(n);
    return row;
  endfunction

  function automatic table_row_t cfg_row(reg_idx_t idx, int value);
    table_row_t row;
    row = capture_row(0, 1'b0, 0);
    row.kind      = ROW_CFG;
    row.reg_sel   = idx;
    row.reg_value = 32'(value);
    return row;
  endfunction

  // Result checker: every beat taken on the output is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (expected_decodes.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want_item = expected_decodes.pop_front();
        if (out_data.width_valid !== want_item.width_valid)
          report_mismatch("width_valid", out_data.width_valid, want_item.width_valid);
        if (out_data.width_channel !== want_item.width_channel)
          report_mismatch("width_channel", out_data.width_channel, want_item.width_channel);
        if (out_data.pulse_width !== want_item.pulse_width)
          report_mismatch("pulse_width", out_data.pulse_width, want_item.pulse_width);
        if (out_data.sync_seen !== want_item.sync_seen)
          report_mismatch("sync_seen", out_data.sync_seen, want_item.sync_seen);
        if (out_data.good_count !== want_item.good_count)
          report_mismatch("good_count", out_data.good_count, want_item.good_count);
        if (out_data.noise_count !== want_item.noise_count)
          report_mismatch("noise_count", out_data.noise_count, want_item.noise_count);
      end
    end
  end

  // Receiver: runs of no stalls, short random drops, occasional long stalls, and one long
  // hold-off while the sender keeps offering beats.
  initial begin
    int  mode_left;
    int  stall_left;
    int  stall_mode;
    int  r;
    bit  hold_done;
    mode_left  = 0;
    stall_left = 0;
    stall_mode = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = 64;
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) stall_left = $urandom_range(10, 40);
        out_ready <= (r >= 30);
      end
    end
  end

  initial begin
    int          p;
    int          k;
    logic [15:0] sync_w;
    logic [3:0]  frames;
    logic [3:0]  fs_ch;
    logic [15:0] fs_lo;
    logic [15:0] fs_hi;
    logic        level;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    model_cfg = '{ppm_mode: 1'b0, ppm_pulse_level: 1'b1,
                  sync_min_width: SYNC_MIN_WIDTH_RST, frame_channels: FRAME_CHANNELS_RST,
                  failsafe_channel: FAILSAFE_CHANNEL_RST, failsafe_low: FAILSAFE_LOW_RST,
                  failsafe_high: FAILSAFE_HIGH_RST};
    for (k = 0; k < NCH; k++) begin
      rise_time[k] = '0;
      gen_high[k]  = 1'b0;
      gen_rise[k]  = '0;
    end
    last_pulse_time = '0;
    frame_slot      = '0;
    good_tally      = '0;
    noise_tally     = '0;
    gen_last_pulse  = '0;

    // PWM with the reset configuration: wrap-around widths, bad channels and window edges.
    stim_table.push_back(known_row(0, 1, 1, 0, 0, 0, 0, 0, 0));
    stim_table.push_back(known_row(2000, 0, 1, 1, 1, 2000, 0, 1, 0));
    stim_table.push_back(known_row(65535, 0, 2, 1, 2, 65535, 0, 1, 0));
    stim_table.push_back(known_row(65535, 1, 8, 0, 0, 0, 0, 1, 0));
    stim_table.push_back(known_row(0, 0, 8, 1, 8, 1, 0, 1, 0));
    stim_table.push_back(known_row(777, 0, 0, 0, 0, 0, 0, 1, 0));
    stim_table.push_back(known_row(4321, 1, 9, 0, 0, 0, 0, 1, 0));
    stim_table.push_back(known_row(4321, 0, 15, 0, 0, 0, 0, 1, 0));
    stim_table.push_back(known_row(1500, 0, 1, 1, 1, 1500, 0, 1, 1));
    stim_table.push_back(known_row(4500, 0, 1, 1, 1, 4500, 0, 1, 2));
    // PPM with fifteen slots: run past the eighth channel until the slot counter wraps.
    stim_table.push_back(cfg_row(REG_PPM_MODE, 1));
    stim_table.push_back(cfg_row(REG_FRAME_CHANNELS, 15));
    stim_table.push_back(known_row(100, 0, 3, 0, 0, 0, 0, 1, 2));
    stim_table.push_back(known_row(10000, 1, 5, 0, 0, 0, 1, 1, 2));
    for (k = 1; k <= 16; k++)
      stim_table.push_back(capture_row(10000 + 2000 * k, 1, k % 16));
    // Inverted pulses, no frame channels and a failsafe channel that never matches.
    stim_table.push_back(cfg_row(REG_PPM_PULSE_LEVEL, 0));
    stim_table.push_back(cfg_row(REG_FRAME_CHANNELS, 0));
    stim_table.push_back(cfg_row(REG_FAILSAFE_CHANNEL, 15));
    stim_table.push_back(capture_row(5000, 0, 1));
    stim_table.push_back(capture_row(6000, 0, 1));
    stim_table.push_back(capture_row(6500, 1, 1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(stim_table[i].reg_sel, stim_table[i].reg_value);
      end else begin
        send_capture(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      level  = 1'($urandom);
      sync_w = 16'($urandom_range(3000, 9000));
      frames = 4'($urandom_range(1, 15));
      fs_ch  = 4'($urandom_range(1, NCH));
      fs_lo  = 16'($urandom_range(500, 2000));
      fs_hi  = 16'($urandom_range(2500, 5000));
      case (p)
        1: sync_w = 16'd0;
        3: sync_w = 16'hFFFF;
        4: begin
          fs_lo = 16'd0;
          fs_hi = 16'hFFFF;
        end
        5: frames = 4'd0;
        6: begin
          fs_lo = 16'hFFFF;
          fs_hi = 16'd0;
        end
        7: frames = 4'd15;
        9: fs_ch = 4'd0;
        10: fs_ch = 4'd15;
        11: begin
          fs_lo = 16'($urandom);
          fs_hi = 16'($urandom);
        end
        default: ;
      endcase
      write_reg(REG_PPM_MODE, 32'(p % 2));
      write_reg(REG_PPM_PULSE_LEVEL, 32'(level));
      write_reg(REG_SYNC_MIN_WIDTH, 32'(sync_w));
      write_reg(REG_FRAME_CHANNELS, 32'(frames));
      write_reg(REG_FAILSAFE_CHANNEL, 32'(fs_ch));
      write_reg(REG_FAILSAFE_LOW, 32'(fs_lo));
      write_reg(REG_FAILSAFE_HIGH, 32'(fs_hi));
      for (k = 0; k < PHASE_BEATS; k++) begin
        if (k % 50 == 0) sender_mode = $urandom_range(0, 2);
        if (items_sent == PAUSE_AT_BEAT) wait_drained();
        send_capture(make_capture(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
